// ----- design/tdrm_pkg.sv -----
package tdrm_pkg;

	// default build values
	localparam int TIME_BITS_DEF        = 48;
	localparam int TICKS_PER_SECOND_DEF = 1000000;
	localparam int EXP_TABLE_DEPTH_DEF  = 256;

	// field widths
	localparam int ARRIVAL_TIME_W  = 48;
	localparam int PACKET_BITS_W   = 19;
	localparam int BETA_W          = 24;
	localparam int PACKET_RATE_W   = 48;
	localparam int BIT_RATE_W      = 56;
	localparam int TOTAL_PACKETS_W = 32;
	localparam int TOTAL_BITS_W    = 48;
	localparam int PEND_COUNT_W    = 16;
	localparam int PEND_BITS_W     = 32;

	// Q.16 fixed point
	localparam int          FRAC_W    = 16;
	localparam int          FACTOR_W  = FRAC_W + 1;
	localparam logic [23:0] BETA_RESET = 24'd65536;

	// sequencer states
	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_MUL    = 9'b000000010,
		ST_DIV    = 9'b000000100,
		ST_TAB0   = 9'b000001000,
		ST_TAB1   = 9'b000010000,
		ST_INTERP = 9'b000100000,
		ST_BLEND  = 9'b001000000,
		ST_FIN    = 9'b010000000,
		ST_DONE   = 9'b100000000
	} state_t;

endpackage

// ----- design/time_decay_rate_meter_unit.sv -----
// Time-decayed packet and bit rate meter. Each arrival item (time in ticks, length in bits)
// gives one result item with the updated packet rate (Q32.16), bit rate (Q40.16) and the
// saturating totals of packets and bits folded so far. For an arrival at a strictly newer
// time, a bit-serial multiply of beta by the time step runs one bit per cycle over
// TIME_BITS bits, then one restoring divider step per cycle over NUM_W bits (81 at the
// default build) yields the two instantaneous rates and the decay table position together,
// and a serial multiply by the interpolated decay factor blends the rates. A first arrival
// at a non-zero time skips the blend. A first arrival at time zero, or an arrival at the
// same or an older time, goes straight to the done state and is handed to the output
// register from there. A new item is taken as soon as the previous result has been handed
// to the output register, even while that result is still stalled. The user must write
// beta through cfg_we and cfg_wdata only while the block is idle; the block itself does
// not enforce this.
module time_decay_rate_meter_unit #(
	parameter int TIME_BITS        = tdrm_pkg::TIME_BITS_DEF,
	parameter int TICKS_PER_SECOND = tdrm_pkg::TICKS_PER_SECOND_DEF,
	parameter int EXP_TABLE_DEPTH  = tdrm_pkg::EXP_TABLE_DEPTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [tdrm_pkg::BETA_W-1:0]           cfg_wdata,
	input  logic                                  arrival_valid,
	output logic                                  arrival_stall,
	input  logic [tdrm_pkg::ARRIVAL_TIME_W-1:0]   arrival_time,
	input  logic [tdrm_pkg::PACKET_BITS_W-1:0]    packet_bits,
	output logic                                  result_valid,
	input  logic                                  result_stall,
	output logic [tdrm_pkg::PACKET_RATE_W-1:0]    packet_rate,
	output logic [tdrm_pkg::BIT_RATE_W-1:0]       bit_rate,
	output logic [tdrm_pkg::TOTAL_PACKETS_W-1:0]  total_packets,
	output logic [tdrm_pkg::TOTAL_BITS_W-1:0]     total_bits
);

	localparam int TB     = TIME_BITS;
	localparam int TPS_W  = $clog2(TICKS_PER_SECOND + 1);
	localparam int DP_W   = $clog2(EXP_TABLE_DEPTH + 1);
	localparam int IX_W   = DP_W;
	localparam int PD_W   = TPS_W + 4;
	localparam int PB_W   = tdrm_pkg::PACKET_BITS_W + TPS_W;
	localparam int NB_W   = PB_W + tdrm_pkg::FRAC_W;
	localparam int BD_W   = tdrm_pkg::BETA_W + DP_W;
	localparam int PM_W   = BD_W + TB;
	localparam int NUM_W0 = (NB_W > PM_W) ? NB_W : PM_W;
	localparam int NUM_W  = (NUM_W0 > 57) ? NUM_W0 : 57;
	localparam int CNT_W  = $clog2(NUM_W);
	localparam int PR_W   = tdrm_pkg::PACKET_RATE_W;
	localparam int BR_W   = tdrm_pkg::BIT_RATE_W;
	localparam int FW     = tdrm_pkg::FACTOR_W;
	localparam int DFP_W  = PR_W + 1;
	localparam int DFB_W  = BR_W + 1;
	localparam int ACP_W  = DFP_W + FW;
	localparam int ACB_W  = DFB_W + FW;
	localparam int TOP_W  = ACP_W + 2;
	localparam int TOB_W  = ACB_W + 2;

	localparam logic [TPS_W-1:0] TPS_V = TPS_W'(TICKS_PER_SECOND);
	localparam logic [PD_W-1:0]  PD_V  = {TPS_V, 4'b0000};
	localparam logic [NUM_W-1:0] LIM_V = NUM_W'(EXP_TABLE_DEPTH) << tdrm_pkg::FRAC_W;
	localparam logic [PR_W-1:0]  PR_MAX = '1;
	localparam logic [BR_W-1:0]  BR_MAX = '1;
	localparam logic [PR_W-1:0]  ONE_Q16 = PR_W'(65536);

	// series argument 16/depth in Q.30
	localparam longint unsigned EXP_STEP = (64'd16 << 30) / EXP_TABLE_DEPTH;

	typedef logic [FW-1:0] exp_tab_t [EXP_TABLE_DEPTH+1];

	// shift and subtract quotient, used only while building the table
	function automatic longint unsigned quot_of(longint unsigned a, longint unsigned b);
		longint unsigned q;
		longint unsigned r;
		q = 64'd0;
		r = 64'd0;
		for (int j = 63; j >= 0; j--) begin
			r = {r[62:0], a[j]};
			q = q << 1;
			if (r >= b) begin
				r = r - b;
				q[0] = 1'b1;
			end
		end
		return q;
	endfunction

	// exp(-16k/depth) in Q1.16, built by repeated Q.30 products
	function automatic exp_tab_t build_exp_tab();
		longint unsigned term;
		longint unsigned sum;
		longint unsigned p;
		exp_tab_t        tab;
		term = 64'd1 << 30;
		sum = term;
		p = 64'd1 << 30;
		for (longint unsigned N = 1; N <= 30; N++) begin
			term = quot_of((term * EXP_STEP) >> 30, N);
			if (N[0])
				sum = (term > sum) ? 64'd0 : sum - term;
			else
				sum = sum + term;
		end
		for (int k = 0; k <= EXP_TABLE_DEPTH; k++) begin
			tab[k] = FW'((p + (64'd1 << 13)) >> 14);
			p = (p * sum) >> 30;
		end
		return tab;
	endfunction

	localparam exp_tab_t EXP_TAB = build_exp_tab();

	tdrm_pkg::state_t state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [tdrm_pkg::BETA_W-1:0] beta_q;

	logic seen_q;
	logic blend_q;
	logic [TB-1:0] last_q;
	logic [tdrm_pkg::PEND_COUNT_W-1:0] pend_c_q;
	logic [tdrm_pkg::PEND_BITS_W-1:0] pend_b_q;
	logic [PR_W-1:0] rate_p_q;
	logic [BR_W-1:0] rate_b_q;
	logic [tdrm_pkg::TOTAL_PACKETS_W-1:0] sum_p_q;
	logic [tdrm_pkg::TOTAL_BITS_W-1:0] sum_b_q;

	logic [TB-1:0] dt_q;
	logic [TB-1:0] mul_q;
	logic [NUM_W-1:0] num_f_q;
	logic [NUM_W-1:0] num_p_q;
	logic [NUM_W-1:0] num_b_q;
	logic [TB-1:0] rem_p_q;
	logic [TB-1:0] rem_b_q;
	logic [PD_W-1:0] rem_f_q;
	logic [NUM_W-1:0] quo_p_q;
	logic [NUM_W-1:0] quo_b_q;
	logic [NUM_W-1:0] quo_f_q;

	logic [PR_W-1:0] inst_p_q;
	logic [BR_W-1:0] inst_b_q;
	logic fzero_q;
	logic [IX_W-1:0] idx_q;
	logic [tdrm_pkg::FRAC_W-1:0] frac_q;
	logic [FW-1:0] t0_q;
	logic [FW-1:0] t1_q;
	logic [FW-1:0] f_q;
	logic [DFP_W-1:0] diff_p_q;
	logic [DFB_W-1:0] diff_b_q;
	logic [ACP_W-1:0] acc_p_q;
	logic [ACB_W-1:0] acc_b_q;

	logic out_valid_q;
	logic [PR_W-1:0] out_pr_q;
	logic [BR_W-1:0] out_br_q;
	logic [tdrm_pkg::TOTAL_PACKETS_W-1:0] out_tp_q;
	logic [tdrm_pkg::TOTAL_BITS_W-1:0] out_tb_q;

	logic accept;
	logic [TB-1:0] t_in;
	logic newer;
	logic [PB_W-1:0] bt_c;
	logic [BD_W-1:0] bd_c;
	logic [tdrm_pkg::TOTAL_PACKETS_W:0] sp_c;
	logic [tdrm_pkg::TOTAL_BITS_W:0] sb_c;
	logic [tdrm_pkg::PEND_BITS_W:0] pb_c;

	logic [TB:0] tr_p, tr_b, sub_p, sub_b;
	logic [PD_W:0] tr_f, sub_f;
	logic ge_p, ge_b, ge_f;

	logic [PR_W-1:0] inst_p_c;
	logic [BR_W-1:0] inst_b_c;
	logic fzero_c;
	logic [IX_W-1:0] idx_c;

	logic [FW-1:0] dlt_c;
	logic [FW+tdrm_pkg::FRAC_W:0] rnd_c;
	logic [FW-1:0] f_c;

	logic [TOP_W-1:0] tot_p;
	logic [TOB_W-1:0] tot_b;
	logic [PR_W-1:0] fin_p;
	logic [BR_W-1:0] fin_b;
	logic out_free;

	// input side
	assign accept        = arrival_valid && !arrival_stall;
	assign arrival_stall = (state_q != tdrm_pkg::ST_IDLE);
	assign t_in          = TB'(arrival_time);
	assign newer         = t_in > last_q;
	assign bt_c          = PB_W'(packet_bits) * PB_W'(TPS_V);
	assign bd_c          = BD_W'(beta_q) * BD_W'(EXP_TABLE_DEPTH);
	assign sp_c          = (tdrm_pkg::TOTAL_PACKETS_W+1)'(sum_p_q) + (tdrm_pkg::TOTAL_PACKETS_W+1)'(pend_c_q);
	assign sb_c          = (tdrm_pkg::TOTAL_BITS_W+1)'(sum_b_q) + (tdrm_pkg::TOTAL_BITS_W+1)'(pend_b_q);
	assign pb_c          = (tdrm_pkg::PEND_BITS_W+1)'(pend_b_q) + (tdrm_pkg::PEND_BITS_W+1)'(packet_bits);

	// restoring divider steps, one quotient bit each
	assign tr_p  = {rem_p_q, num_p_q[NUM_W-1]};
	assign tr_b  = {rem_b_q, num_b_q[NUM_W-1]};
	assign tr_f  = {rem_f_q, num_f_q[NUM_W-1]};
	assign sub_p = tr_p - {1'b0, dt_q};
	assign sub_b = tr_b - {1'b0, dt_q};
	assign sub_f = tr_f - {1'b0, PD_V};
	assign ge_p  = tr_p >= {1'b0, dt_q};
	assign ge_b  = tr_b >= {1'b0, dt_q};
	assign ge_f  = tr_f >= {1'b0, PD_V};

	// saturated quotients and table position
	assign inst_p_c = (quo_p_q > NUM_W'(PR_MAX)) ? PR_MAX : quo_p_q[PR_W-1:0];
	assign inst_b_c = (quo_b_q > NUM_W'(BR_MAX)) ? BR_MAX : quo_b_q[BR_W-1:0];
	assign fzero_c  = quo_f_q >= LIM_V;
	assign idx_c    = fzero_c ? '0 : quo_f_q[tdrm_pkg::FRAC_W +: IX_W];

	// linear interpolation between neighbouring table entries
	assign dlt_c = t0_q - t1_q;
	assign rnd_c = (FW+tdrm_pkg::FRAC_W+1)'(dlt_c * frac_q) + (FW+tdrm_pkg::FRAC_W+1)'(32768);
	assign f_c   = fzero_q ? '0 : t0_q - rnd_c[FW+tdrm_pkg::FRAC_W-1:tdrm_pkg::FRAC_W];

	// rounding and saturation of f*(old-inst) + inst
	assign tot_p = {{2{acc_p_q[ACP_W-1]}}, acc_p_q} + (TOP_W'(inst_p_q) << tdrm_pkg::FRAC_W)
		+ TOP_W'(32768);
	assign tot_b = {{2{acc_b_q[ACB_W-1]}}, acc_b_q} + (TOB_W'(inst_b_q) << tdrm_pkg::FRAC_W)
		+ TOB_W'(32768);
	assign fin_p = (|tot_p[TOP_W-1:PR_W+tdrm_pkg::FRAC_W]) ? PR_MAX
		: tot_p[PR_W+tdrm_pkg::FRAC_W-1:tdrm_pkg::FRAC_W];
	assign fin_b = (|tot_b[TOB_W-1:BR_W+tdrm_pkg::FRAC_W]) ? BR_MAX
		: tot_b[BR_W+tdrm_pkg::FRAC_W-1:tdrm_pkg::FRAC_W];

	assign out_free = !out_valid_q || !result_stall;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			beta_q <= tdrm_pkg::BETA_RESET;
		else if (cfg_we)
			beta_q <= cfg_wdata;
	end

	// sequencer and meter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= tdrm_pkg::ST_IDLE;
			cnt_q    <= '0;
			seen_q   <= 1'b0;
			blend_q  <= 1'b0;
			last_q   <= '0;
			pend_c_q <= '0;
			pend_b_q <= '0;
			rate_p_q <= '0;
			rate_b_q <= '0;
			sum_p_q  <= '0;
			sum_b_q  <= '0;
		end else begin
			case (state_q)
				tdrm_pkg::ST_IDLE: begin
					if (accept) begin
						dt_q    <= t_in - last_q;
						mul_q   <= t_in - last_q;
						num_f_q <= '0;
						num_p_q <= NUM_W'({TPS_V, 16'h0000});
						num_b_q <= NUM_W'({bt_c, 16'h0000});
						rem_p_q <= '0;
						rem_b_q <= '0;
						rem_f_q <= '0;
						cnt_q   <= CNT_W'(TB - 1);
						blend_q <= seen_q;
						if (!seen_q || newer) begin
							// fold pending counts and restart them with this packet
							if (seen_q) begin
								sum_p_q <= sp_c[tdrm_pkg::TOTAL_PACKETS_W] ? '1
									: sp_c[tdrm_pkg::TOTAL_PACKETS_W-1:0];
								sum_b_q <= sb_c[tdrm_pkg::TOTAL_BITS_W] ? '1
									: sb_c[tdrm_pkg::TOTAL_BITS_W-1:0];
							end
							seen_q   <= 1'b1;
							last_q   <= t_in;
							pend_c_q <= tdrm_pkg::PEND_COUNT_W'(1);
							pend_b_q <= tdrm_pkg::PEND_BITS_W'(packet_bits);
							if (!seen_q && t_in == '0) begin
								rate_p_q <= ONE_Q16;
								rate_b_q <= BR_W'({packet_bits, 16'h0000});
								state_q  <= tdrm_pkg::ST_DONE;
							end else begin
								state_q <= tdrm_pkg::ST_MUL;
							end
						end else begin
							if (pend_c_q != '1)
								pend_c_q <= pend_c_q + 1'b1;
							pend_b_q <= pb_c[tdrm_pkg::PEND_BITS_W] ? '1
								: pb_c[tdrm_pkg::PEND_BITS_W-1:0];
							state_q <= tdrm_pkg::ST_DONE;
						end
					end
				end
				tdrm_pkg::ST_MUL: begin
					// beta*depth*dt, one bit of dt per cycle
					num_f_q <= (num_f_q << 1) + (mul_q[TB-1] ? NUM_W'(bd_c) : '0);
					mul_q   <= mul_q << 1;
					cnt_q   <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						cnt_q   <= CNT_W'(NUM_W - 1);
						state_q <= tdrm_pkg::ST_DIV;
					end
				end
				tdrm_pkg::ST_DIV: begin
					num_p_q <= num_p_q << 1;
					num_b_q <= num_b_q << 1;
					num_f_q <= num_f_q << 1;
					rem_p_q <= ge_p ? sub_p[TB-1:0] : tr_p[TB-1:0];
					rem_b_q <= ge_b ? sub_b[TB-1:0] : tr_b[TB-1:0];
					rem_f_q <= ge_f ? sub_f[PD_W-1:0] : tr_f[PD_W-1:0];
					quo_p_q <= {quo_p_q[NUM_W-2:0], ge_p};
					quo_b_q <= {quo_b_q[NUM_W-2:0], ge_b};
					quo_f_q <= {quo_f_q[NUM_W-2:0], ge_f};
					cnt_q   <= cnt_q - 1'b1;
					if (cnt_q == '0)
						state_q <= tdrm_pkg::ST_TAB0;
				end
				tdrm_pkg::ST_TAB0: begin
					inst_p_q <= inst_p_c;
					inst_b_q <= inst_b_c;
					fzero_q  <= fzero_c;
					frac_q   <= quo_f_q[tdrm_pkg::FRAC_W-1:0];
					t0_q     <= EXP_TAB[idx_c];
					idx_q    <= idx_c + 1'b1;
					if (blend_q) begin
						state_q <= tdrm_pkg::ST_TAB1;
					end else begin
						// first arrival: rates are the instantaneous ones
						rate_p_q <= inst_p_c;
						rate_b_q <= inst_b_c;
						state_q  <= tdrm_pkg::ST_DONE;
					end
				end
				tdrm_pkg::ST_TAB1: begin
					t1_q     <= EXP_TAB[idx_q];
					diff_p_q <= {1'b0, rate_p_q} - {1'b0, inst_p_q};
					diff_b_q <= {1'b0, rate_b_q} - {1'b0, inst_b_q};
					state_q  <= tdrm_pkg::ST_INTERP;
				end
				tdrm_pkg::ST_INTERP: begin
					f_q     <= f_c;
					acc_p_q <= '0;
					acc_b_q <= '0;
					cnt_q   <= CNT_W'(FW - 1);
					state_q <= tdrm_pkg::ST_BLEND;
				end
				tdrm_pkg::ST_BLEND: begin
					// f*(old-inst), factor bits taken msb first
					acc_p_q <= (acc_p_q << 1)
						+ (f_q[FW-1] ? {{FW{diff_p_q[DFP_W-1]}}, diff_p_q} : '0);
					acc_b_q <= (acc_b_q << 1)
						+ (f_q[FW-1] ? {{FW{diff_b_q[DFB_W-1]}}, diff_b_q} : '0);
					f_q   <= f_q << 1;
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0)
						state_q <= tdrm_pkg::ST_FIN;
				end
				tdrm_pkg::ST_FIN: begin
					rate_p_q <= fin_p;
					rate_b_q <= fin_b;
					state_q  <= tdrm_pkg::ST_DONE;
				end
				tdrm_pkg::ST_DONE: begin
					if (out_free)
						state_q <= tdrm_pkg::ST_IDLE;
				end
				default: begin
					state_q <= tdrm_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == tdrm_pkg::ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == tdrm_pkg::ST_DONE && out_free) begin
			out_pr_q <= rate_p_q;
			out_br_q <= rate_b_q;
			out_tp_q <= sum_p_q;
			out_tb_q <= sum_b_q;
		end
	end

	assign result_valid  = out_valid_q;
	assign packet_rate   = out_pr_q;
	assign bit_rate      = out_br_q;
	assign total_packets = out_tp_q;
	assign total_bits    = out_tb_q;

	// an accepted item always starts the sequencer
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != tdrm_pkg::ST_IDLE)
		else $error("item accepted but sequencer stayed idle");

	// after the first item the pending count always holds that item or later ones
	a_pending_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q |-> pend_c_q != '0)
		else $error("pending count empty after first item");

	// a finished result waits while the output register is held
	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tdrm_pkg::ST_DONE && out_valid_q && result_stall)
		|=> state_q == tdrm_pkg::ST_DONE && $stable(out_pr_q))
		else $error("result overwritten while output stalled");

endmodule
